[design/blle_pkg.sv]
`default_nettype none

package blle_pkg;

	localparam int NODE_W = 10;
	localparam int LEN_W  = 11;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_BUILD = 2'd1,
		REQ_LCA   = 2'd2,
		REQ_KTH   = 2'd3
	} req_type_t;

	typedef struct packed {
		req_type_t           req_type;
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
		logic [NODE_W-1:0]   parent_node;
		logic [NODE_W-1:0]   node_depth;
		logic [NODE_W-1:0]   step_count;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0]   answer_node;
		logic [LEN_W-1:0]    path_length;
	} rsp_t;

	typedef struct packed {
		logic                we;
		logic [NODE_W-1:0]   node;
		logic [NODE_W-1:0]   data;
	} wr_t;

endpackage

`default_nettype wire

[design/blle_ram.sv]
`default_nettype none

module blle_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata0_q;
	logic [WIDTH-1:0] rdata1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0_q <= mem_q[raddr0];
		rdata1_q <= mem_q[raddr1];
	end

	assign rdata0 = rdata0_q;
	assign rdata1 = rdata1_q;

endmodule

`default_nettype wire

[design/blle_tables.sv]
`default_nettype none

module blle_tables #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  logic                                clk,
	input  blle_pkg::wr_t                       anc_wr,
	input  logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] anc_wr_lvl,
	input  logic [blle_pkg::NODE_W-1:0]         anc_rd_node0,
	input  logic [blle_pkg::NODE_W-1:0]         anc_rd_node1,
	input  logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] anc_rd_lvl,
	output logic [blle_pkg::NODE_W-1:0]         anc_rd_data0,
	output logic [blle_pkg::NODE_W-1:0]         anc_rd_data1,
	input  blle_pkg::wr_t                       dep_wr,
	input  logic [blle_pkg::NODE_W-1:0]         dep_rd_node0,
	input  logic [blle_pkg::NODE_W-1:0]         dep_rd_node1,
	output logic [blle_pkg::NODE_W-1:0]         dep_rd_data0,
	output logic [blle_pkg::NODE_W-1:0]         dep_rd_data1
);

	localparam int NW        = blle_pkg::NODE_W;
	localparam int ANC_DEPTH = LEVELS * (1 << NW);
	localparam int ANC_AW    = $clog2(ANC_DEPTH);
	localparam int DEP_DEPTH = 1 << NW;

	function automatic logic node_ok(input logic [NW-1:0] n);
		return (n != '0) && (32'(n) < NODES);
	endfunction

	logic [NW-1:0] anc_raw0, anc_raw1, dep_raw0, dep_raw1;
	logic          anc_zero0_q, anc_zero1_q, dep_zero0_q, dep_zero1_q;

	blle_ram #(.WIDTH(NW), .DEPTH(ANC_DEPTH)) u_anc_ram (
		.clk    (clk),
		.we     (anc_wr.we && node_ok(anc_wr.node)),
		.waddr  (ANC_AW'({anc_wr_lvl, anc_wr.node})),
		.wdata  (anc_wr.data),
		.raddr0 (ANC_AW'({anc_rd_lvl, anc_rd_node0})),
		.raddr1 (ANC_AW'({anc_rd_lvl, anc_rd_node1})),
		.rdata0 (anc_raw0),
		.rdata1 (anc_raw1)
	);

	blle_ram #(.WIDTH(NW), .DEPTH(DEP_DEPTH)) u_dep_ram (
		.clk    (clk),
		.we     (dep_wr.we && node_ok(dep_wr.node)),
		.waddr  (dep_wr.node),
		.wdata  (dep_wr.data),
		.raddr0 (dep_rd_node0),
		.raddr1 (dep_rd_node1),
		.rdata0 (dep_raw0),
		.rdata1 (dep_raw1)
	);

	// sentinel and out-of-range nodes read as zero
	always_ff @(posedge clk) begin
		anc_zero0_q <= !node_ok(anc_rd_node0);
		anc_zero1_q <= !node_ok(anc_rd_node1);
		dep_zero0_q <= !node_ok(dep_rd_node0);
		dep_zero1_q <= !node_ok(dep_rd_node1);
	end

	assign anc_rd_data0 = anc_zero0_q ? '0 : anc_raw0;
	assign anc_rd_data1 = anc_zero1_q ? '0 : anc_raw1;
	assign dep_rd_data0 = dep_zero0_q ? '0 : dep_raw0;
	assign dep_rd_data1 = dep_zero1_q ? '0 : dep_raw1;

endmodule

`default_nettype wire

[design/binary_lifting_lca_engine_core.sv]
// Binary-lifting LCA engine. The tree lives in two synchronous RAMs: an ancestor table of
// LEVELS x 1024 entries addressed {level, node} and a depth table of 1024 entries; node 0
// and nodes of NODES or more read as the sentinel. Neither table is cleared after reset, so
// every node must be loaded before it is queried. A load gives no result. A build gives
// no result and holds req_ready low while it fills levels 1 to LEVELS-1 for nodes 1 to
// N-1, N = min(NODES,1024): each entry needs two dependent ancestor reads and a write. In
// an lca query the depth-matching pass steps through ST_L1_UP and ST_L1_CMP at each level
// for its dependent ancestor-then-depth read, the joint pass through ST_L2 at each level
// with both ancestor ports read together. A kth-ancestor query walks the levels down in
// ST_K and passes through ST_K_RD for each level climbed. The result sits in an output
// register, and the next item is taken while it waits to be drained.
`default_nettype none

module binary_lifting_lca_engine_core #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  blle_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output blle_pkg::rsp_t rsp
);

	localparam int NW       = blle_pkg::NODE_W;
	localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int NODE_CNT = (NODES < (1 << NW)) ? NODES : (1 << NW);
	localparam logic [NW-1:0] J_LAST  = NW'(NODE_CNT - 1);
	localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_L_DEP,
		ST_L1_UP,
		ST_L1_CMP,
		ST_L1_END,
		ST_L2,
		ST_L_PAR,
		ST_L_LEN,
		ST_K,
		ST_K_RD,
		ST_B_RD1,
		ST_B_RD2,
		ST_B_WR,
		ST_RESULT
	} state_t;

	state_t                      state_q;
	logic [NW-1:0]               x_q, y_q, up_q, l_q, dy_q, da_q, db_q, k_q, j_q;
	logic [LW-1:0]               lvl_q, blvl_q;
	blle_pkg::rsp_t              res_q, rsp_q;
	logic                        rsp_valid_q;

	blle_pkg::wr_t               anc_wr, dep_wr;
	logic [LW-1:0]               anc_wr_lvl, anc_rd_lvl;
	logic [NW-1:0]               anc_rd_node0, anc_rd_node1, dep_rd_node0, dep_rd_node1;
	logic [NW-1:0]               anc_rd_data0, anc_rd_data1, dep_rd_data0, dep_rd_data1;

	logic                        req_accept;
	logic                        dep_swap, l2_take, k_take;
	logic [NW-1:0]               sx, sy, sdy, l1_nx, l2_nx, l2_ny, k_w;
	logic [LW-1:0]               lvl_dn;
	logic [blle_pkg::LEN_W-1:0]  len;

	assign req_ready  = (state_q == ST_IDLE);
	assign req_accept = req_valid && req_ready;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign dep_swap = dep_rd_data0 < dep_rd_data1;
	assign sx       = dep_swap ? y_q : x_q;
	assign sy       = dep_swap ? x_q : y_q;
	assign sdy      = dep_swap ? dep_rd_data0 : dep_rd_data1;
	assign l1_nx    = (dep_rd_data0 >= dy_q) ? up_q : x_q;
	assign l2_take  = (anc_rd_data0 != anc_rd_data1) && (anc_rd_data0 != '0)
		&& (anc_rd_data1 != '0);
	assign l2_nx    = l2_take ? anc_rd_data0 : x_q;
	assign l2_ny    = l2_take ? anc_rd_data1 : y_q;
	assign k_w      = NW'(1) << lvl_q;
	assign k_take   = (32'(lvl_q) < NW) && (k_q >= k_w);
	assign lvl_dn   = lvl_q - LW'(1);
	assign len      = {1'b0, da_q} + {1'b0, db_q} - {dep_rd_data0, 1'b0};

	blle_tables #(.NODES(NODES), .LEVELS(LEVELS)) u_tables (
		.clk          (clk),
		.anc_wr       (anc_wr),
		.anc_wr_lvl   (anc_wr_lvl),
		.anc_rd_node0 (anc_rd_node0),
		.anc_rd_node1 (anc_rd_node1),
		.anc_rd_lvl   (anc_rd_lvl),
		.anc_rd_data0 (anc_rd_data0),
		.anc_rd_data1 (anc_rd_data1),
		.dep_wr       (dep_wr),
		.dep_rd_node0 (dep_rd_node0),
		.dep_rd_node1 (dep_rd_node1),
		.dep_rd_data0 (dep_rd_data0),
		.dep_rd_data1 (dep_rd_data1)
	);

	always_comb begin
		anc_rd_node0 = x_q;
		anc_rd_node1 = y_q;
		anc_rd_lvl   = lvl_q;
		dep_rd_node0 = x_q;
		dep_rd_node1 = y_q;
		anc_wr       = '{we: 1'b0, node: j_q, data: anc_rd_data0};
		anc_wr_lvl   = blvl_q;
		dep_wr       = '{we: 1'b0, node: req.node_a, data: req.node_depth};
		unique case (state_q)
			ST_IDLE: begin
				dep_rd_node0 = req.node_a;
				dep_rd_node1 = req.node_b;
				anc_wr = '{we: req_accept && (req.req_type == blle_pkg::REQ_LOAD),
					node: req.node_a, data: req.parent_node};
				anc_wr_lvl = '0;
				dep_wr.we = req_accept && (req.req_type == blle_pkg::REQ_LOAD);
			end
			ST_L_DEP: begin
				anc_rd_node0 = sx;
				anc_rd_lvl   = LVL_TOP;
			end
			ST_L1_UP: begin
				dep_rd_node0 = anc_rd_data0;
			end
			ST_L1_CMP: begin
				anc_rd_node0 = l1_nx;
				anc_rd_lvl   = lvl_dn;
			end
			ST_L1_END: begin
				anc_rd_lvl = LVL_TOP;
			end
			ST_L2: begin
				anc_rd_node0 = l2_nx;
				anc_rd_node1 = l2_ny;
				anc_rd_lvl   = (lvl_q == '0) ? '0 : lvl_dn;
			end
			ST_L_PAR: begin
				dep_rd_node0 = anc_rd_data0;
			end
			ST_L_LEN, ST_K, ST_K_RD, ST_RESULT: begin
			end
			ST_B_RD1: begin
				anc_rd_node0 = j_q;
				anc_rd_lvl   = blvl_q - LW'(1);
			end
			ST_B_RD2: begin
				anc_rd_node0 = anc_rd_data0;
				anc_rd_lvl   = blvl_q - LW'(1);
			end
			ST_B_WR: begin
				anc_wr.we = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			res_q       <= '0;
			x_q         <= '0;
			y_q         <= '0;
			up_q        <= '0;
			l_q         <= '0;
			dy_q        <= '0;
			da_q        <= '0;
			db_q        <= '0;
			k_q         <= '0;
			j_q         <= '0;
			lvl_q       <= '0;
			blvl_q      <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && (state_q != ST_RESULT)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						x_q    <= req.node_a;
						y_q    <= req.node_b;
						k_q    <= req.step_count;
						lvl_q  <= LVL_TOP;
						j_q    <= NW'(1);
						blvl_q <= LW'(1);
						unique case (req.req_type)
							blle_pkg::REQ_LOAD:  state_q <= ST_IDLE;
							blle_pkg::REQ_BUILD: state_q <= (LEVELS > 1) ? ST_B_RD1 : ST_IDLE;
							blle_pkg::REQ_LCA:   state_q <= ST_L_DEP;
							blle_pkg::REQ_KTH:   state_q <= ST_K;
						endcase
					end
				end
				ST_L_DEP: begin
					da_q    <= dep_rd_data0;
					db_q    <= dep_rd_data1;
					x_q     <= sx;
					y_q     <= sy;
					dy_q    <= sdy;
					state_q <= ST_L1_UP;
				end
				ST_L1_UP: begin
					up_q    <= anc_rd_data0;
					state_q <= ST_L1_CMP;
				end
				ST_L1_CMP: begin
					x_q <= l1_nx;
					if (lvl_q == '0) begin
						state_q <= ST_L1_END;
					end else begin
						lvl_q   <= lvl_dn;
						state_q <= ST_L1_UP;
					end
				end
				ST_L1_END: begin
					if (x_q == y_q) begin
						l_q     <= x_q;
						state_q <= ST_L_LEN;
					end else begin
						lvl_q   <= LVL_TOP;
						state_q <= ST_L2;
					end
				end
				ST_L2: begin
					x_q <= l2_nx;
					y_q <= l2_ny;
					if (lvl_q == '0) begin
						state_q <= ST_L_PAR;
					end else begin
						lvl_q <= lvl_dn;
					end
				end
				ST_L_PAR: begin
					l_q     <= anc_rd_data0;
					state_q <= ST_L_LEN;
				end
				ST_L_LEN: begin
					res_q   <= '{answer_node: l_q, path_length: len};
					state_q <= ST_RESULT;
				end
				ST_K: begin
					if (k_take) begin
						k_q     <= k_q - k_w;
						state_q <= ST_K_RD;
					end else if (lvl_q == '0) begin
						res_q   <= '{answer_node: x_q, path_length: '0};
						state_q <= ST_RESULT;
					end else begin
						lvl_q <= lvl_dn;
					end
				end
				ST_K_RD: begin
					x_q <= anc_rd_data0;
					if (lvl_q == '0) begin
						res_q   <= '{answer_node: anc_rd_data0, path_length: '0};
						state_q <= ST_RESULT;
					end else begin
						lvl_q   <= lvl_dn;
						state_q <= ST_K;
					end
				end
				ST_B_RD1: state_q <= ST_B_RD2;
				ST_B_RD2: state_q <= ST_B_WR;
				ST_B_WR: begin
					if (j_q == J_LAST) begin
						j_q <= NW'(1);
						if (blvl_q == LVL_TOP) begin
							state_q <= ST_IDLE;
						end else begin
							blvl_q  <= blvl_q + LW'(1);
							state_q <= ST_B_RD1;
						end
					end else begin
						j_q     <= j_q + NW'(1);
						state_q <= ST_B_RD1;
					end
				end
				ST_RESULT: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	a_query_blocks_next: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept && (req.req_type == blle_pkg::REQ_LCA || req.req_type == blle_pkg::REQ_KTH)
		|=> !req_ready)
		else $error("query accepted back to back");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(lvl_q <= LVL_TOP) && (blvl_q <= LVL_TOP))
		else $error("level counter out of range");

	a_build_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_B_WR) |-> (anc_wr_lvl != '0) && (j_q != '0) && (j_q <= J_LAST))
		else $error("build writes level zero or an invalid node");

	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) && rsp_valid_q && !rsp_ready |=> (state_q == ST_RESULT))
		else $error("result dropped while output register full");

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODE_W       = blle_pkg::NODE_W;
	localparam int LEN_W        = blle_pkg::LEN_W;
	localparam int NODE_COUNT   = 1024;
	localparam int LIFT_LEVELS  = 10;
	localparam int RANDOM_ITEMS = 560;
	localparam int LONG_HOLD    = 400;

	typedef struct packed {
		blle_pkg::req_t item;
		logic typed;
		blle_pkg::rsp_t want;
	} probe_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	blle_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	blle_pkg::rsp_t rsp;

	logic [NODE_W-1:0] lift_tbl [NODE_COUNT][LIFT_LEVELS];
	logic [NODE_W-1:0] depth_tbl [NODE_COUNT];
	blle_pkg::rsp_t answers [$];
	blle_pkg::rsp_t expected_rsp;
	probe_t directed [$];
	logic hold_long = 1'b0;
	int send_calm = 0;
	int drain_calm = 0;
	int n_load = 0;
	int n_build = 0;
	int n_lca = 0;
	int n_kth = 0;
	int n_checked = 0;
	int n_errors = 0;

	binary_lifting_lca_engine_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	function automatic logic [NODE_W-1:0] anc_at(input logic [NODE_W-1:0] node, input int lvl);
		return (node == '0) ? '0 : lift_tbl[node][lvl];
	endfunction

	function automatic logic [NODE_W-1:0] depth_at(input logic [NODE_W-1:0] node);
		return (node == '0) ? '0 : depth_tbl[node];
	endfunction

	function automatic logic [NODE_W-1:0] meet_point(input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b);
		logic [NODE_W-1:0] x;
		logic [NODE_W-1:0] y;
		logic [NODE_W-1:0] ux;
		logic [NODE_W-1:0] uy;
		x = a;
		y = b;
		if (depth_at(x) < depth_at(y)) begin
			x = b;
			y = a;
		end
		for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
			ux = anc_at(x, i);
			if (depth_at(ux) >= depth_at(y))
				x = ux;
		end
		if (x == y)
			return x;
		for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
			ux = anc_at(x, i);
			uy = anc_at(y, i);
			if (ux != uy && ux != '0 && uy != '0) begin
				x = ux;
				y = uy;
			end
		end
		return anc_at(x, 0);
	endfunction

	function automatic logic [NODE_W-1:0] climb_from(input logic [NODE_W-1:0] node, input int steps);
		logic [NODE_W-1:0] x;
		int k;
		x = node;
		k = steps;
		for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
			if (k >= (1 << i)) begin
				x = anc_at(x, i);
				k -= (1 << i);
			end
		end
		return x;
	endfunction

	function automatic logic apply_request(input blle_pkg::req_t r, output blle_pkg::rsp_t res);
		logic [NODE_W-1:0] top;
		int span;
		logic produces;
		res = '0;
		produces = 1'b1;
		case (r.req_type)
			blle_pkg::REQ_LOAD: begin
				produces = 1'b0;
				if (r.node_a != '0) begin
					lift_tbl[r.node_a][0] = r.parent_node;
					depth_tbl[r.node_a] = r.node_depth;
				end
			end
			blle_pkg::REQ_BUILD: begin
				produces = 1'b0;
				for (int l = 1; l < LIFT_LEVELS; l++)
					for (int j = 1; j < NODE_COUNT; j++)
						lift_tbl[j][l] = anc_at(anc_at(NODE_W'(j), l - 1), l - 1);
			end
			blle_pkg::REQ_LCA: begin
				top = meet_point(r.node_a, r.node_b);
				span = int'(depth_at(r.node_a)) + int'(depth_at(r.node_b))
					- 2 * int'(depth_at(top));
				res.answer_node = top;
				res.path_length = LEN_W'(span);
			end
			default: begin
				res.answer_node = climb_from(r.node_a, int'(r.step_count));
			end
		endcase
		return produces;
	endfunction

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			calm = $urandom_range(20, 80);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int rnd();
		return $urandom_range(0, NODE_COUNT - 1);
	endfunction

	function automatic blle_pkg::req_t make_req(input blle_pkg::req_type_t kind, input int a,
			input int b, input int p, input int d, input int k);
		blle_pkg::req_t r;
		r.req_type    = kind;
		r.node_a      = NODE_W'(a);
		r.node_b      = NODE_W'(b);
		r.parent_node = NODE_W'(p);
		r.node_depth  = NODE_W'(d);
		r.step_count  = NODE_W'(k);
		return r;
	endfunction

	function automatic void add_row(input blle_pkg::req_t item, input logic typed, input int ans,
			input int len);
		probe_t pr;
		pr.item = item;
		pr.typed = typed;
		pr.want.answer_node = NODE_W'(ans);
		pr.want.path_length = LEN_W'(len);
		directed.insert(directed.size(), pr);
	endfunction

	task automatic report(input string what, input int got, input int want);
		n_errors++;
		if (n_errors <= 20)
			$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	task automatic offer(input blle_pkg::req_t item, input logic typed,
			input blle_pkg::rsp_t want);
		blle_pkg::rsp_t got;
		int gap;
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		if (apply_request(item, got))
			answers.insert(answers.size(), typed ? want : got);
		case (item.req_type)
			blle_pkg::REQ_LOAD:  n_load++;
			blle_pkg::REQ_BUILD: n_build++;
			blle_pkg::REQ_LCA:   n_lca++;
			default:             n_kth++;
		endcase
		gap = pick_gap(send_calm);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (answers.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (answers.size() == 0) begin
				report("unexpected beat", int'(rsp.answer_node), -1);
			end else begin
				expected_rsp = answers.pop_front();
				n_checked++;
				if (rsp.answer_node !== expected_rsp.answer_node)
					report("answer_node", int'(rsp.answer_node), int'(expected_rsp.answer_node));
				if (rsp.path_length !== expected_rsp.path_length)
					report("path_length", int'(rsp.path_length), int'(expected_rsp.path_length));
			end
		end
	end

	initial begin : drain
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				hold_long = 1'b0;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			gap = pick_gap(drain_calm);
			if (gap != 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : watchdog
		#25ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		blle_pkg::req_t item;
		blle_pkg::rsp_t none;
		int pick;
		int a;
		int b;
		int p;
		int k;
		none = '0;
		for (int j = 0; j < NODE_COUNT; j++) begin
			depth_tbl[j] = '0;
			for (int l = 0; l < LIFT_LEVELS; l++)
				lift_tbl[j][l] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int v = 1; v < NODE_COUNT; v++) begin
			pick = $urandom_range(0, 99);
			if (v == 1 || pick < 2)
				p = 0;
			else if (pick < 55)
				p = v - 1;
			else if (pick < 88)
				p = v - 1 - $urandom_range(0, (v - 2 < 30) ? v - 2 : 30);
			else
				p = $urandom_range(1, v - 1);
			item = make_req(blle_pkg::REQ_LOAD, v, rnd(), p,
				(p == 0) ? 1 : int'(depth_at(NODE_W'(p))) + 1, rnd());
			offer(item, 1'b0, none);
		end
		offer(make_req(blle_pkg::REQ_BUILD, rnd(), rnd(), rnd(), rnd(), rnd()), 1'b0, none);

		add_row(make_req(blle_pkg::REQ_LOAD, 0, 0, 5, 7, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 0, 0, 0, 0, 0), 1'b1, 0, 0);
		add_row(make_req(blle_pkg::REQ_KTH, 0, 0, 0, 0, 1023), 1'b1, 0, 0);
		add_row(make_req(blle_pkg::REQ_KTH, 1, 0, 0, 0, 1), 1'b1, 0, 0);
		add_row(make_req(blle_pkg::REQ_KTH, 1023, 0, 0, 0, 0), 1'b1, 1023, 0);
		add_row(make_req(blle_pkg::REQ_KTH, 1023, 1023, 1023, 1023, 1023), 1'b1, 0, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 1023, 1023, 0, 0, 0), 1'b1, 1023, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 1, 1, 0, 0, 0), 1'b1, 1, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 1023, 1, 0, 0, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 1023, 1022, 0, 0, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 1023, 0, 0, 0, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 0, 512, 0, 0, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_KTH, 512, 0, 0, 0, 512), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_KTH, 1023, 0, 0, 0, 1), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_LOAD, 1023, 0, 1023, 1023, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 1023, 1, 0, 0, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_KTH, 1023, 0, 0, 0, 1023), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_LOAD, 1022, 0, 0, 0, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 1022, 1023, 0, 0, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_BUILD, 0, 0, 0, 0, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 1023, 512, 0, 0, 0), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_KTH, 1022, 0, 0, 0, 512), 1'b0, 0, 0);
		add_row(make_req(blle_pkg::REQ_LCA, 1, 1022, 0, 0, 0), 1'b0, 0, 0);
		foreach (directed[i])
			offer(directed[i].item, directed[i].typed, directed[i].want);

		hold_long = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 120 || n == 380)
				settle();
			pick = $urandom_range(0, 99);
			if (n == 200 || n == 330 || n == 470) begin
				item = make_req(blle_pkg::REQ_BUILD, rnd(), rnd(), rnd(), rnd(), rnd());
			end else if (pick < 6) begin
				a = $urandom_range(2, NODE_COUNT - 1);
				p = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, a - 1);
				item = make_req(blle_pkg::REQ_LOAD, a, rnd(), p,
					(p == 0) ? 1 : int'(depth_at(NODE_W'(p))) + 1, rnd());
			end else if (pick < 9) begin
				item = make_req(blle_pkg::REQ_LOAD, rnd(), rnd(), rnd(), rnd(), rnd());
			end else if (pick < 55) begin
				a = (pick < 12) ? 0 : $urandom_range(1, NODE_COUNT - 1);
				pick = $urandom_range(0, 99);
				if (pick < 30)
					b = int'(climb_from(NODE_W'(a),
						$urandom_range(0, int'(depth_at(NODE_W'(a))))));
				else if (pick < 35)
					b = 0;
				else
					b = $urandom_range(1, NODE_COUNT - 1);
				if ($urandom_range(0, 1))
					item = make_req(blle_pkg::REQ_LCA, a, b, rnd(), rnd(), rnd());
				else
					item = make_req(blle_pkg::REQ_LCA, b, a, rnd(), rnd(), rnd());
			end else begin
				a = (pick < 58) ? 0 : $urandom_range(1, NODE_COUNT - 1);
				k = int'(depth_at(NODE_W'(a))) + 1;
				if (k > NODE_COUNT - 1)
					k = NODE_COUNT - 1;
				k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, k) : rnd();
				item = make_req(blle_pkg::REQ_KTH, a, rnd(), rnd(), rnd(), k);
			end
			offer(item, 1'b0, none);
		end

		settle();
		repeat (100) @(posedge clk);
		$display("Covered %0d loads, %0d table builds, %0d lca and %0d kth-ancestor queries.",
			n_load, n_build, n_lca, n_kth);
		$display("Checked %0d result beats, %0d mismatches.", n_checked, n_errors);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[binary_lifting_lca_engine_core.f]
design/blle_pkg.sv
design/blle_ram.sv
design/blle_tables.sv
design/binary_lifting_lca_engine_core.sv
tb/testbench.sv
